>>> rtl/core/cfpc_pkg.sv
// Package for the framed packet checker: word types, register indexes and the CRC-16 step.
package cfpc_pkg;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcTop  = 16'h8000;

  localparam int unsigned HeaderBytes = 6;
  localparam int unsigned PosWidth    = 17;
  localparam logic [PosWidth-1:0] PosMax = {PosWidth{1'b1}};

  localparam logic [7:0] MagicFirstReset  = 8'hAA;
  localparam logic [7:0] MagicSecondReset = 8'h55;

  // configuration register indexes
  localparam logic CfgMagicFirst  = 1'b0;
  localparam logic CfgMagicSecond = 1'b1;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_buffer;
  } in_word_t;

  typedef struct packed {
    logic        frame_status;
    logic [7:0]  command_id;
    logic [7:0]  sequence_number;
    logic [15:0] payload_length;
    logic [15:0] computed_crc;
    logic [15:0] received_crc;
  } out_word_t;

  // CRC-16-CCITT, MSB first, one byte unrolled
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CrcTop) != 16'h0000) c = {c[14:0], 1'b0} ^ CrcPoly;
      else                          c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

>>> rtl/core/crc_framed_packet_checker_unit.sv
// Receive-side checker for CRC-16 framed packets, one buffer byte per word.
//
// Usage:
//   in channel  (in_valid/in_ready/in_data): one buffer byte per word, with
//     end_of_buffer set on the final byte of the buffer.
//   out channel (out_valid/out_ready/out_data): one word per complete frame
//     with good magic, carrying header fields, both CRCs and a status bit.
//     Short frames and frames with wrong magic produce no word at all.
//   cfg port (cfg_we/cfg_index/cfg_data): magic byte registers, to be written
//     only while the block is idle; the block itself does not enforce this.
// Pipeline: two register stages, input register then result register; a final
//   byte moves on to the result register unless a result word waits untaken.
// Throughput: one byte per cycle unless a result byte is held (Stalls); the
//   unrolled 8-bit CRC step from input to state registers sets this figure.
// Stalls: while a result word waits in the output register, bytes keep
//   flowing; only a second result-producing byte holds in the input
//   register, and in_ready drops until the output register is taken.
// Reset: synchronous active-high rst clears both stages, restores magic
//   registers to AA/55 and the frame state to its start-of-buffer values.
module crc_framed_packet_checker_unit
  import cfpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  // configuration
  logic [7:0] magic_first;
  logic [7:0] magic_second;

  // input register
  logic     s1_valid;
  in_word_t s1_word;

  // frame state
  logic [PosWidth-1:0] byte_position;
  logic [15:0]         crc_accumulator;
  logic                magic_ok;
  logic [7:0]          held_command;
  logic [7:0]          held_sequence;
  logic [15:0]         held_length;
  logic [15:0]         held_frame_crc;

  logic [PosWidth-1:0] byte_position_next;
  logic [15:0]         crc_accumulator_next;
  logic                magic_ok_next;
  logic [7:0]          held_command_next;
  logic [7:0]          held_sequence_next;
  logic [15:0]         held_length_next;
  logic [15:0]         held_frame_crc_next;

  logic [PosWidth-1:0] body_end;
  logic [PosWidth-1:0] need_count;
  logic [15:0]         crc_step;
  logic                emit;
  logic                s1_advance;

  assign body_end   = PosWidth'(HeaderBytes) + {1'b0, held_length};
  assign crc_step   = crc16_byte(crc_accumulator, s1_word.rx_byte);

  // per-byte state update, from the byte's position in the buffer
  always_comb begin
    magic_ok_next        = magic_ok;
    held_command_next    = held_command;
    held_sequence_next   = held_sequence;
    held_length_next     = held_length;
    held_frame_crc_next  = held_frame_crc;
    crc_accumulator_next = crc_accumulator;

    if (byte_position < PosWidth'(HeaderBytes)) begin
      case (byte_position[2:0])
        3'd0:    magic_ok_next = (s1_word.rx_byte == magic_first);
        3'd1:    magic_ok_next = magic_ok && (s1_word.rx_byte == magic_second);
        3'd2:    held_command_next = s1_word.rx_byte;
        3'd3:    held_sequence_next = s1_word.rx_byte;
        3'd4:    held_length_next = {s1_word.rx_byte, held_length[7:0]};
        default: held_length_next = {held_length[15:8], s1_word.rx_byte};
      endcase
      crc_accumulator_next = crc_step;
    end else if (byte_position < body_end) begin
      crc_accumulator_next = crc_step;
    end else if (byte_position == body_end) begin
      held_frame_crc_next = {s1_word.rx_byte, held_frame_crc[7:0]};
    end else if (byte_position == body_end + PosWidth'(1)) begin
      held_frame_crc_next = {held_frame_crc[15:8], s1_word.rx_byte};
    end

    byte_position_next = (byte_position < PosMax) ? byte_position + PosWidth'(1)
                                                  : byte_position;
  end

  // frame must hold header, payload and both CRC bytes
  assign need_count = PosWidth'(HeaderBytes + 2) + {1'b0, held_length_next};
  assign emit = s1_word.end_of_buffer && magic_ok_next &&
                (byte_position_next >= PosWidth'(HeaderBytes + 2)) &&
                (byte_position_next >= need_count);

  // byte leaves the input register unless it needs a busy output register
  assign s1_advance = s1_valid && (!emit || !out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_first  <= MagicFirstReset;
      magic_second <= MagicSecondReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgMagicFirst:  magic_first  <= cfg_data;
        CfgMagicSecond: magic_second <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) s1_word <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      crc_accumulator <= CrcInit;
      magic_ok        <= 1'b1;
      held_command    <= '0;
      held_sequence   <= '0;
      held_length     <= '0;
      held_frame_crc  <= '0;
    end else if (s1_advance) begin
      if (s1_word.end_of_buffer) begin
        // buffer done: back to start-of-buffer state
        byte_position   <= '0;
        crc_accumulator <= CrcInit;
        magic_ok        <= 1'b1;
        held_command    <= '0;
        held_sequence   <= '0;
        held_length     <= '0;
        held_frame_crc  <= '0;
      end else begin
        byte_position   <= byte_position_next;
        crc_accumulator <= crc_accumulator_next;
        magic_ok        <= magic_ok_next;
        held_command    <= held_command_next;
        held_sequence   <= held_sequence_next;
        held_length     <= held_length_next;
        held_frame_crc  <= held_frame_crc_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_advance && emit) begin
      out_data.frame_status    <= (crc_accumulator_next != held_frame_crc_next);
      out_data.command_id      <= held_command_next;
      out_data.sequence_number <= held_sequence_next;
      out_data.payload_length  <= held_length_next;
      out_data.computed_crc    <= crc_accumulator_next;
      out_data.received_crc    <= held_frame_crc_next;
    end
  end

endmodule

>>> bench/tb_crc_framed_packet_checker_unit.sv
// Self-checking testbench for the CRC-16 framed packet checker unit.
module tb_crc_framed_packet_checker_unit;
  import cfpc_pkg::*;

  localparam int HoldCycles   = 300;   // long output stall in the pressure test
  localparam int WatchdogMax  = 2000;  // cycles with no handshake before giving up
  localparam int DrainCycles  = 4;     // pipeline is two stages deep
  localparam int RandomBytes  = 425;   // per random phase, four phases

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;
  logic      cfg_we;
  logic      cfg_index;
  logic [7:0] cfg_data;

  crc_framed_packet_checker_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Frame tracker: mirrors the checker's per-buffer state and the magic
  // registers, and queues the report word each accepted final byte should give.
  // ---------------------------------------------------------------------------
  logic [7:0]  want_first  = MagicFirstReset;
  logic [7:0]  want_second = MagicSecondReset;
  logic [16:0] pos         = '0;
  logic [15:0] crc_run     = CrcInit;
  bit          magic_match = 1'b1;
  logic [7:0]  cmd_seen    = '0;
  logic [7:0]  seq_seen    = '0;
  logic [15:0] len_seen    = '0;
  logic [15:0] crc_carried = '0;

  out_word_t pending_reports[$];
  out_word_t oldest_report;
  logic [7:0] buffer_bytes[$];

  int  fail_count      = 0;
  int  bytes_accepted  = 0;
  int  buffers_sent    = 0;
  int  buffers_dropped = 0;
  int  reports_checked = 0;
  int  stall_cycles    = 0;
  bit  bursts_on       = 1'b1;
  bit  hold_request    = 1'b0;

  // CCITT step, one bit per pass: feedback is the top bit xor the data bit
  function automatic logic [15:0] crc_after_byte(logic [15:0] crc, logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = crc[15] ^ d[i];
      crc = {crc[14:0], 1'b0};
      if (fb) crc = crc ^ CrcPoly;
    end
    return crc;
  endfunction

  task automatic restart_frame();
    pos         = '0;
    crc_run     = CrcInit;
    magic_match = 1'b1;
    cmd_seen    = '0;
    seq_seen    = '0;
    len_seen    = '0;
    crc_carried = '0;
  endtask

  task automatic track_byte(input logic [7:0] d, input bit last);
    int p;
    int body_end;
    out_word_t rpt;
    p        = int'(pos);
    body_end = HeaderBytes + int'(len_seen);
    if (p < HeaderBytes) begin
      case (p)
        0: magic_match = (d == want_first);
        1: magic_match = magic_match && (d == want_second);
        2: cmd_seen = d;
        3: seq_seen = d;
        4: len_seen[15:8] = d;
        default: len_seen[7:0] = d;
      endcase
      crc_run = crc_after_byte(crc_run, d);
    end else if (p < body_end) begin
      crc_run = crc_after_byte(crc_run, d);
    end else if (p == body_end) begin
      crc_carried[15:8] = d;
    end else if (p == body_end + 1) begin
      crc_carried[7:0] = d;
    end
    // trailing bytes past the CRC only move the position, which saturates
    if (pos != PosMax) pos = pos + 1'b1;
    if (!last) return;
    if (int'(pos) < HeaderBytes + 2 || !magic_match ||
        int'(pos) < HeaderBytes + int'(len_seen) + 2) begin
      buffers_dropped++;
    end else begin
      rpt.frame_status    = (crc_run != crc_carried);
      rpt.command_id      = cmd_seen;
      rpt.sequence_number = seq_seen;
      rpt.payload_length  = len_seen;
      rpt.computed_crc    = crc_run;
      rpt.received_crc    = crc_carried;
      pending_reports.push_back(rpt);
    end
    restart_frame();
  endtask

  // ---------------------------------------------------------------------------
  // Input side: one word per call, optional idle burst in front.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] d, input bit last);
    in_word_t w;
    int gap;
    w.rx_byte       = d;
    w.end_of_buffer = last;
    @(negedge clk);
    if (bursts_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    track_byte(d, last);
    bytes_accepted++;
  endtask

  task automatic park_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic send_buffer();
    foreach (buffer_bytes[i]) send_byte(buffer_bytes[i], i == buffer_bytes.size() - 1);
    buffers_sent++;
  endtask

  // header, random payload, CRC (optionally corrupted), trailing filler
  task automatic compose_frame(input logic [7:0] m0, input logic [7:0] m1,
                               input logic [7:0] cmd, input logic [7:0] seq,
                               input logic [15:0] len, input bit crc_good,
                               input int trail);
    logic [15:0] c;
    buffer_bytes.delete();
    buffer_bytes.push_back(m0);
    buffer_bytes.push_back(m1);
    buffer_bytes.push_back(cmd);
    buffer_bytes.push_back(seq);
    buffer_bytes.push_back(len[15:8]);
    buffer_bytes.push_back(len[7:0]);
    for (int i = 0; i < int'(len); i++) buffer_bytes.push_back(8'($urandom));
    c = CrcInit;
    foreach (buffer_bytes[i]) c = crc_after_byte(c, buffer_bytes[i]);
    if (!crc_good) c = c ^ 16'($urandom_range(1, 65535));
    buffer_bytes.push_back(c[15:8]);
    buffer_bytes.push_back(c[7:0]);
    for (int i = 0; i < trail; i++) buffer_bytes.push_back(8'($urandom));
  endtask

  task automatic cut_buffer(input int keep);
    while (buffer_bytes.size() > keep) void'(buffer_bytes.pop_back());
  endtask

  // wait for every queued report, then let the pipeline flush dropped frames
  task automatic drain();
    park_input();
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [7:0] val);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CfgMagicFirst) want_first = val;
    else                      want_second = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random ready bursts, plus one long hold on request.
  // ---------------------------------------------------------------------------
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_request = 1'b0;
      end else if (bursts_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 12)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endfunction

  // every report word taken is compared against the oldest one queued
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $error("report word with nothing queued: %h", out_data);
        fail_count++;
      end else begin
        oldest_report = pending_reports.pop_front();
        check_field("frame_status", 16'(oldest_report.frame_status), 16'(out_data.frame_status));
        check_field("command_id", 16'(oldest_report.command_id), 16'(out_data.command_id));
        check_field("sequence_number", 16'(oldest_report.sequence_number),
                    16'(out_data.sequence_number));
        check_field("payload_length", oldest_report.payload_length, out_data.payload_length);
        check_field("computed_crc", oldest_report.computed_crc, out_data.computed_crc);
        check_field("received_crc", oldest_report.received_crc, out_data.received_crc);
        reports_checked++;
      end
    end
  end

  // no handshake of any kind for too long means the block hung
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WatchdogMax) begin
      $display("watchdog: no handshake for %0d cycles", stall_cycles);
      $display("crc_framed_packet_checker_unit regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // shortest good frame with field extremes; bad CRC with a trailing byte
  task automatic test_directed_frames();
    compose_frame(want_first, want_second, 8'h00, 8'hFF, 16'h0000, 1'b1, 0);
    send_buffer();
    compose_frame(want_first, want_second, 8'hFF, 8'h00, 16'h0000, 1'b0, 1);
    send_buffer();
  endtask

  // silent drops: lone byte, header claiming 0xFFFF bytes, wrong second magic
  task automatic test_directed_drops();
    send_byte(want_first, 1'b1);
    buffers_sent++;
    compose_frame(want_first, want_second, 8'h5A, 8'hA5, 16'h0000, 1'b1, 0);
    buffer_bytes[4] = 8'hFF;
    buffer_bytes[5] = 8'hFF;
    cut_buffer(HeaderBytes);
    send_buffer();
    compose_frame(want_first, ~want_second, 8'h11, 8'h22, 16'h0000, 1'b1, 0);
    send_buffer();
  endtask

  // output held off long enough that two reports back up and input stalls
  task automatic test_output_backpressure();
    drain();
    hold_request = 1'b1;
    repeat (12) begin
      compose_frame(want_first, want_second, 8'($urandom), 8'($urandom),
                    16'($urandom_range(0, 3)), $urandom_range(0, 1), 0);
      send_buffer();
    end
  endtask

  // mostly well-formed frames with random content, the rest broken or noise
  task automatic test_random_traffic(input int budget);
    int start;
    int kind;
    int len;
    start = bytes_accepted;
    while (bytes_accepted - start < budget) begin
      kind = $urandom_range(0, 99);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 16);
      compose_frame(want_first, want_second, 8'($urandom), 8'($urandom), 16'(len),
                    $urandom_range(0, 4) != 0,
                    ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0);
      if (kind >= 60 && kind < 72) begin
        cut_buffer($urandom_range(1, buffer_bytes.size() - 1));
      end else if (kind >= 72 && kind < 84) begin
        if ($urandom_range(0, 1)) buffer_bytes[0] = buffer_bytes[0] ^ 8'($urandom_range(1, 255));
        else                      buffer_bytes[1] = buffer_bytes[1] ^ 8'($urandom_range(1, 255));
      end else if (kind >= 84) begin
        // noise, sometimes behind valid magic so random length fields get parsed
        buffer_bytes.delete();
        repeat ($urandom_range(1, 14)) buffer_bytes.push_back(8'($urandom));
        if (buffer_bytes.size() >= 2 && $urandom_range(0, 1)) begin
          buffer_bytes[0] = want_first;
          buffer_bytes[1] = want_second;
        end
      end
      send_buffer();
    end
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = CfgMagicFirst;
    cfg_data  = '0;
    restart_frame();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_frames();
    test_directed_drops();
    test_output_backpressure();

    // register extremes first, then a random pair, back to reset values last
    write_register(CfgMagicFirst, 8'h00);
    write_register(CfgMagicSecond, 8'hFF);
    test_random_traffic(RandomBytes);
    write_register(CfgMagicFirst, 8'hFF);
    write_register(CfgMagicSecond, 8'h00);
    test_random_traffic(RandomBytes);
    write_register(CfgMagicFirst, 8'($urandom));
    write_register(CfgMagicSecond, 8'($urandom));
    test_random_traffic(RandomBytes);
    write_register(CfgMagicFirst, MagicFirstReset);
    write_register(CfgMagicSecond, MagicSecondReset);

    // closing stretch runs at full rate on both sides
    bursts_on = 1'b0;
    test_random_traffic(RandomBytes);

    park_input();
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d bytes in %0d buffers: %0d report words checked, %0d dropped",
             bytes_accepted, buffers_sent, reports_checked, buffers_dropped);
    $display("magic settings 00/FF, FF/00, random, AA/55; %0d-cycle output hold",
             HoldCycles);
    if (fail_count == 0) begin
      $display("crc_framed_packet_checker_unit regression: pass");
    end else begin
      $display("crc_framed_packet_checker_unit regression: fail");
    end
    $finish;
  end

endmodule
